### design/bounded_array_list_engine_top_macros.svh
// assertion macros for the array list engine
`ifndef BOUNDED_ARRAY_LIST_ENGINE_TOP_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define BALE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define BALE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bale_pkg.sv
// shared types, codes and sizes of the array list engine
package bale_pkg;

  localparam int CAPACITY = 8;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // rotate source index before the wrap back into range
  localparam int SRC_W    = CNT_W + 1;

  localparam int MODE_W  = 4;
  localparam int POS_W   = 8;
  localparam int VAL_W   = 32;
  localparam int SH_W    = 8;
  localparam int STAT_W  = 3;
  localparam int FOUND_W = 4;
  localparam int ENT_W   = 4;
  localparam int DCNT_W  = $clog2(SH_W);

  localparam logic [ENT_W-1:0] CAP_ENTRIES = ENT_W'(CAPACITY);

  localparam logic [MODE_W-1:0] MODE_INS_FRONT = 4'd0;
  localparam logic [MODE_W-1:0] MODE_INS_END   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_INS_POS   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 4'd3;
  localparam logic [MODE_W-1:0] MODE_DEL_END   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_DEL_POS   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_SEARCH    = 4'd6;
  localparam logic [MODE_W-1:0] MODE_DUMP      = 4'd7;
  localparam logic [MODE_W-1:0] MODE_ROTATE    = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic [SH_W-1:0]         shift;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [FOUND_W-1:0]      found_at;
    logic signed [VAL_W-1:0] element;
    logic [ENT_W-1:0]        entries;
    logic                    last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              clr_j;
    logic              div_init;
    logic              div_step;
    logic              copy_step;
    logic              read_step;
    logic              commit;
    logic              emit;
    logic [STAT_W-1:0] emit_status;
    logic              emit_found;
    logic              emit_elem;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              empty;
    logic              pos_ins_ok;
    logic              pos_del_ok;
    logic              copy_none;
    logic              copy_last;
    logic              div_last;
    logic              scan_more;
    logic              pv;
    logic              hit;
    logic              dump_last;
  } dp_stat_t;

endpackage

### design/bale_datapath.sv
// list storage, copy engine, modulo unit and result register
module bale_datapath (
  input  logic               clk,
  input  logic               rst,
  input  bale_pkg::item_t    item,
  input  bale_pkg::dp_cmd_t  cmd,
  output bale_pkg::dp_stat_t stat,
  output logic               done,
  output bale_pkg::result_t  result
);

  bale_pkg::item_t item_q;

  logic [bale_pkg::VAL_W-1:0] mem0 [bale_pkg::CAPACITY];
  logic [bale_pkg::VAL_W-1:0] mem1 [bale_pkg::CAPACITY];
  logic [bale_pkg::VAL_W-1:0] rdata0;
  logic [bale_pkg::VAL_W-1:0] rdata1;
  logic [bale_pkg::VAL_W-1:0] rdata_act;
  logic [bale_pkg::VAL_W-1:0] wdata;
  logic                       bank;

  logic [bale_pkg::CNT_W-1:0] count;
  logic [bale_pkg::CNT_W-1:0] count_next;
  logic [bale_pkg::CNT_W-1:0] j;
  logic [bale_pkg::CNT_W-1:0] pj;
  logic                       pv;
  logic [bale_pkg::IDX_W-1:0] wj;
  logic                       wv;
  logic                       wuse;

  logic [bale_pkg::CNT_W-1:0]  rem;
  logic [bale_pkg::SH_W-1:0]   dvd;
  logic [bale_pkg::DCNT_W-1:0] dcnt;
  logic [bale_pkg::CNT_W:0]    trial;

  logic                       is_ins;
  logic                       is_del;
  logic [bale_pkg::CNT_W-1:0] pt;
  logic [bale_pkg::POS_W-1:0] pos_m1;
  logic [bale_pkg::SRC_W-1:0] src;
  logic [bale_pkg::SRC_W-1:0] rot_t;
  logic                       use_val;

  always_comb begin
    is_ins = (item_q.mode == bale_pkg::MODE_INS_FRONT) ||
             (item_q.mode == bale_pkg::MODE_INS_END) ||
             (item_q.mode == bale_pkg::MODE_INS_POS);
    is_del = (item_q.mode == bale_pkg::MODE_DEL_FRONT) ||
             (item_q.mode == bale_pkg::MODE_DEL_END) ||
             (item_q.mode == bale_pkg::MODE_DEL_POS);
    pos_m1 = item_q.position - 1'b1;
    case (item_q.mode)
      bale_pkg::MODE_INS_END: pt = count;
      bale_pkg::MODE_DEL_END: pt = count - 1'b1;
      bale_pkg::MODE_INS_POS,
      bale_pkg::MODE_DEL_POS: pt = bale_pkg::CNT_W'(pos_m1);
      default:                pt = '0;
    endcase
    if (is_ins) begin
      count_next = count + 1'b1;
    end else if (is_del) begin
      count_next = count - 1'b1;
    end else begin
      count_next = count;
    end
  end

  // source slot in the current bank for destination slot j
  always_comb begin
    src     = {1'b0, j};
    use_val = 1'b0;
    rot_t   = {1'b0, j} + {1'b0, count} - {1'b0, rem};
    if (is_ins) begin
      if (j == pt) begin
        use_val = 1'b1;
      end else if (j > pt) begin
        src = {1'b0, j} - 1'b1;
      end
    end else if (is_del) begin
      if (j >= pt) begin
        src = {1'b0, j} + 1'b1;
      end
    end else if (item_q.mode == bale_pkg::MODE_ROTATE) begin
      src = (rot_t >= {1'b0, count}) ? rot_t - {1'b0, count} : rot_t;
    end
  end

  assign rdata_act = bank ? rdata1 : rdata0;
  assign wdata     = wuse ? item_q.value : rdata_act;
  assign trial     = {rem, dvd[bale_pkg::SH_W-1]};

  always_ff @(posedge clk) begin
    if (wv) begin
      if (bank) begin
        mem0[wj] <= wdata;
      end else begin
        mem1[wj] <= wdata;
      end
    end
    rdata0 <= mem0[src[bale_pkg::IDX_W-1:0]];
    rdata1 <= mem1[src[bale_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
    if (cmd.clr_j) begin
      j <= '0;
    end else if (cmd.copy_step || cmd.read_step) begin
      j <= j + 1'b1;
    end
    pj   <= j;
    wj   <= j[bale_pkg::IDX_W-1:0];
    wuse <= use_val;
    // restoring remainder, one dividend bit per cycle
    if (cmd.div_init) begin
      rem  <= '0;
      dvd  <= item_q.shift;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= (trial >= {1'b0, count}) ? bale_pkg::CNT_W'(trial - {1'b0, count})
                                        : trial[bale_pkg::CNT_W-1:0];
      dvd  <= dvd << 1;
      dcnt <= dcnt + 1'b1;
    end
    if (cmd.emit) begin
      result.status   <= cmd.emit_status;
      result.found_at <= cmd.emit_found ? bale_pkg::FOUND_W'({1'b0, pj} + 1'b1) : '0;
      result.element  <= cmd.emit_elem ? rdata_act : '0;
      result.entries  <= cmd.commit ? bale_pkg::ENT_W'(count_next)
                                    : bale_pkg::ENT_W'(count);
      result.last     <= cmd.emit_elem ? stat.dump_last : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      bank  <= 1'b0;
      wv    <= 1'b0;
      pv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      wv   <= cmd.copy_step;
      pv   <= cmd.read_step;
      done <= cmd.emit;
      if (cmd.commit) begin
        count <= count_next;
        bank  <= ~bank;
      end
    end
  end

  always_comb begin
    stat.mode       = item_q.mode;
    stat.full       = (count >= bale_pkg::CNT_W'(bale_pkg::CAPACITY));
    stat.empty      = (count == '0);
    stat.pos_ins_ok = (item_q.position != '0) &&
                      ({1'b0, item_q.position} <= 9'({1'b0, count} + 1'b1));
    stat.pos_del_ok = (item_q.position != '0) &&
                      ({1'b0, item_q.position} <= 9'(count));
    stat.copy_none  = (count_next == '0);
    stat.copy_last  = (bale_pkg::CNT_W'(j + 1'b1) == count_next);
    stat.div_last   = (dcnt == bale_pkg::DCNT_W'(bale_pkg::SH_W - 1));
    stat.scan_more  = (j < count);
    stat.pv         = pv;
    stat.hit        = pv && (rdata_act == $unsigned(item_q.value));
    stat.dump_last  = (bale_pkg::CNT_W'(pj + 1'b1) == count);
  end

endmodule

### design/bale_ctrl.sv
// operation sequencer of the array list engine
module bale_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  bale_pkg::dp_stat_t stat,
  output bale_pkg::dp_cmd_t  cmd,
  output logic               busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_COPY,
    S_COPY_END,
    S_SCAN,
    S_DUMP
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.clr_j = 1'b1;
        case (stat.mode)
          bale_pkg::MODE_INS_FRONT,
          bale_pkg::MODE_INS_END,
          bale_pkg::MODE_INS_POS: begin
            if (stat.full) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = bale_pkg::ST_FULL;
              state_next      = S_IDLE;
            end else if (stat.mode == bale_pkg::MODE_INS_POS && !stat.pos_ins_ok) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = bale_pkg::ST_BADPOS;
              state_next      = S_IDLE;
            end else begin
              state_next = S_COPY;
            end
          end
          bale_pkg::MODE_DEL_FRONT,
          bale_pkg::MODE_DEL_END,
          bale_pkg::MODE_DEL_POS: begin
            if (stat.empty) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = bale_pkg::ST_EMPTY;
              state_next      = S_IDLE;
            end else if (stat.mode == bale_pkg::MODE_DEL_POS && !stat.pos_del_ok) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = bale_pkg::ST_BADPOS;
              state_next      = S_IDLE;
            end else if (stat.copy_none) begin
              // last entry removed, nothing to move
              cmd.commit      = 1'b1;
              cmd.emit        = 1'b1;
              cmd.emit_status = bale_pkg::ST_OK;
              state_next      = S_IDLE;
            end else begin
              state_next = S_COPY;
            end
          end
          bale_pkg::MODE_SEARCH: begin
            if (stat.empty) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = bale_pkg::ST_NOTFOUND;
              state_next      = S_IDLE;
            end else begin
              state_next = S_SCAN;
            end
          end
          bale_pkg::MODE_DUMP: begin
            if (stat.empty) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = bale_pkg::ST_EMPTY;
              state_next      = S_IDLE;
            end else begin
              state_next = S_DUMP;
            end
          end
          bale_pkg::MODE_ROTATE: begin
            if (stat.empty) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = bale_pkg::ST_OK;
              state_next      = S_IDLE;
            end else begin
              cmd.div_init = 1'b1;
              state_next   = S_DIV;
            end
          end
          default: begin
            cmd.emit        = 1'b1;
            cmd.emit_status = bale_pkg::ST_OK;
            state_next      = S_IDLE;
          end
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_COPY;
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (stat.copy_last) begin
          state_next = S_COPY_END;
        end
      end
      S_COPY_END: begin
        // final write lands in the spare bank at this edge, as the banks swap
        cmd.commit      = 1'b1;
        cmd.emit        = 1'b1;
        cmd.emit_status = bale_pkg::ST_OK;
        state_next      = S_IDLE;
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = bale_pkg::ST_OK;
          cmd.emit_found  = 1'b1;
          state_next      = S_IDLE;
        end else if (stat.pv && !stat.scan_more) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = bale_pkg::ST_NOTFOUND;
          state_next      = S_IDLE;
        end else begin
          cmd.read_step = stat.scan_more;
        end
      end
      S_DUMP: begin
        cmd.read_step = stat.scan_more;
        if (stat.pv) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = bale_pkg::ST_OK;
          cmd.emit_elem   = 1'b1;
          if (stat.dump_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

### design/bounded_array_list_engine_top.sv
// top level of the bounded array list engine
//
// holds an ordered list of up to CAPACITY signed 32-bit values and a count.
// a transaction is taken at a rising edge with start high and busy low; the
// item carries mode, position, value and shift. busy stays high until the
// last result of that transaction has been issued.
// each result appears on result for exactly one cycle with done high; the
// receiver cannot stall, so results are never held back. a dump gives one
// result per entry on consecutive cycles, last set on the final one; every
// other operation gives a single result with last set.
// errors and trivial cases are answered from the decide step, with no copy.
// insert and delete copy the surviving entries into a second bank, one
// entry per cycle through the registered memory read, except a delete that
// empties the list, which answers from the decide step with no copy.
// rotate first finds shift mod count one bit a cycle, then copies; search
// stops at the first match. the next transaction can be taken while a
// result is out.
// reset clears the count and control state; stored values need no clearing.
module bounded_array_list_engine_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bale_pkg::item_t   item,
  output logic              done,
  output bale_pkg::result_t result
);

  `include "bounded_array_list_engine_top_macros.svh"

  bale_pkg::dp_cmd_t  cmd;
  bale_pkg::dp_stat_t stat;
  logic               ent_in_range;
  logic               full_res;
  logic               full_at_cap;

  bale_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bale_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

  assign ent_in_range = (result.entries <= bale_pkg::CAP_ENTRIES);
  assign full_res     = done && (result.status == bale_pkg::ST_FULL);
  assign full_at_cap  = (result.entries == bale_pkg::CAP_ENTRIES);

  `BALE_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "busy not raised after accept")
  `BALE_ASSERT_NEXT(a_dump_burst, clk, rst, done && !result.last, done, "gap in dump burst")
  `BALE_ASSERT_IMPL(a_entries_range, clk, rst, done, ent_in_range, "entries above capacity")
  `BALE_ASSERT_IMPL(a_full_count, clk, rst, full_res, full_at_cap, "full reported below capacity")

endmodule
